### rtl/core/pfm_pkg.sv
package pfm_pkg;

   localparam int NUM_DEVICES_DEFAULT = 3;
   localparam int NUM_DEVICES_MAX     = 8;

   localparam int DEVICE_W      = 3;
   localparam int LIVENESS_W    = 32;
   localparam int COUNT_W       = 16;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

   localparam logic [COUNT_W-1:0] TIMEOUT_TICKS_RESET     = 16'd10;
   localparam logic [COUNT_W-1:0] STUCK_TICKS_RESET       = 16'd50;
   localparam logic [COUNT_W-1:0] IMPLAUSIBLE_TICKS_RESET = 16'd10;
   localparam logic [COUNT_W-1:0] BUS_STUCK_TICKS_RESET   = 16'd3;

   typedef enum logic [0:0] {
      OP_REPORT = 1'b0,
      OP_TICK   = 1'b1
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FITTED_MASK       = 3'd0,
      CSR_TIMEOUT_TICKS     = 3'd1,
      CSR_STUCK_TICKS       = 3'd2,
      CSR_IMPLAUSIBLE_TICKS = 3'd3,
      CSR_BUS_STUCK_TICKS   = 3'd4
   } csr_index_type;

endpackage

### rtl/core/pfm_req_if.sv
interface pfm_req_if
   import pfm_pkg::*;
   ;
   logic                  valid;
   logic                  ready;
   logic                  operation;
   logic [DEVICE_W-1:0]   device;
   logic                  read_ok;
   logic                  plausible;
   logic [LIVENESS_W-1:0] liveness;
   logic                  clock_line_high;
   logic                  data_line_high;

   modport source (
      output valid, operation, device, read_ok, plausible, liveness,
             clock_line_high, data_line_high,
      input  ready
   );

   modport sink (
      input  valid, operation, device, read_ok, plausible, liveness,
             clock_line_high, data_line_high,
      output ready
   );
endinterface

### rtl/core/pfm_rsp_if.sv
interface pfm_rsp_if
   import pfm_pkg::*;
#(
   parameter int NUM_DEVICES = NUM_DEVICES_DEFAULT
);
   logic                   valid;
   logic                   ready;
   logic                   clock_line_stuck;
   logic                   data_line_stuck;
   logic [NUM_DEVICES-1:0] no_response_mask;
   logic [NUM_DEVICES-1:0] timeout_mask;
   logic [NUM_DEVICES-1:0] stuck_mask;
   logic [NUM_DEVICES-1:0] implausible_mask;

   modport source (
      output valid, clock_line_stuck, data_line_stuck, no_response_mask,
             timeout_mask, stuck_mask, implausible_mask,
      input  ready
   );

   modport sink (
      input  valid, clock_line_stuck, data_line_stuck, no_response_mask,
             timeout_mask, stuck_mask, implausible_mask,
      output ready
   );
endinterface

### rtl/core/peripheral_fault_monitor_top.sv
// a tick passes the input register, then its result is held in the result register
// throughput: one item per cycle while nothing stalls; reports and ticks may follow back to back
// a held result stalls a tick in the input register and all items behind it; a report there still moves on
// reset is synchronous, active high: clears device and bus state but last liveness, loads register defaults
// (fitted mask zero, thresholds 10, 50, 10, 3)
module peripheral_fault_monitor_top
   import pfm_pkg::*;
#(
   parameter int NUM_DEVICES = NUM_DEVICES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   pfm_req_if.sink                req_chan,
   pfm_rsp_if.source              rsp_chan,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   function automatic logic [COUNT_W-1:0] sat_count(input logic [COUNT_W-1:0] c,
                                                   input logic active);
      logic [COUNT_W-1:0] r;
      if (!active) begin
         r = '0;
      end else if (c < COUNT_MAX) begin
         r = c + COUNT_W'(1);
      end else begin
         r = c;
      end
      return r;
   endfunction

   // configuration registers
   logic [NUM_DEVICES-1:0] fitted_ff, fitted_in;
   logic [COUNT_W-1:0]     timeout_ticks_ff, timeout_ticks_in;
   logic [COUNT_W-1:0]     stuck_ticks_ff, stuck_ticks_in;
   logic [COUNT_W-1:0]     impl_ticks_ff, impl_ticks_in;
   logic [COUNT_W-1:0]     bus_ticks_ff, bus_ticks_in;

   always_comb begin
      fitted_in        = fitted_ff;
      timeout_ticks_in = timeout_ticks_ff;
      stuck_ticks_in   = stuck_ticks_ff;
      impl_ticks_in    = impl_ticks_ff;
      bus_ticks_in     = bus_ticks_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_FITTED_MASK:       fitted_in        = csr_wdata[NUM_DEVICES-1:0];
            CSR_TIMEOUT_TICKS:     timeout_ticks_in = csr_wdata;
            CSR_STUCK_TICKS:       stuck_ticks_in   = csr_wdata;
            CSR_IMPLAUSIBLE_TICKS: impl_ticks_in    = csr_wdata;
            CSR_BUS_STUCK_TICKS:   bus_ticks_in     = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fitted_ff        <= '0;
         timeout_ticks_ff <= TIMEOUT_TICKS_RESET;
         stuck_ticks_ff   <= STUCK_TICKS_RESET;
         impl_ticks_ff    <= IMPLAUSIBLE_TICKS_RESET;
         bus_ticks_ff     <= BUS_STUCK_TICKS_RESET;
      end else begin
         fitted_ff        <= fitted_in;
         timeout_ticks_ff <= timeout_ticks_in;
         stuck_ticks_ff   <= stuck_ticks_in;
         impl_ticks_ff    <= impl_ticks_in;
         bus_ticks_ff     <= bus_ticks_in;
      end
   end

   // input register
   logic                  s1_valid_ff, s1_valid_in;
   op_type                s1_op_ff;
   logic [DEVICE_W-1:0]   s1_device_ff;
   logic                  s1_read_ok_ff;
   logic                  s1_plausible_ff;
   logic [LIVENESS_W-1:0] s1_liveness_ff;
   logic                  s1_clk_high_ff;
   logic                  s1_dat_high_ff;

   logic s1_advance;
   logic s1_fire;
   logic req_fire;

   // a report never needs the result register, so it cannot be held up
   assign s1_advance = (s1_op_ff == OP_REPORT) || !rsp_chan.valid || rsp_chan.ready;
   assign s1_fire    = s1_valid_ff && s1_advance;
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign req_fire   = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff        <= op_type'(req_chan.operation);
         s1_device_ff    <= req_chan.device;
         s1_read_ok_ff   <= req_chan.read_ok;
         s1_plausible_ff <= req_chan.plausible;
         s1_liveness_ff  <= req_chan.liveness;
         s1_clk_high_ff  <= req_chan.clock_line_high;
         s1_dat_high_ff  <= req_chan.data_line_high;
      end
   end

   // device and bus state
   logic [NUM_DEVICES-1:0] ever_ff, ever_in;
   logic [NUM_DEVICES-1:0] win_ans_ff, win_ans_in;
   logic [NUM_DEVICES-1:0] win_impl_ff, win_impl_in;
   logic [NUM_DEVICES-1:0] last_valid_ff, last_valid_in;
   logic [LIVENESS_W-1:0]  last_live_ff [NUM_DEVICES];
   logic [LIVENESS_W-1:0]  last_live_in [NUM_DEVICES];
   logic [COUNT_W-1:0]     silent_cnt_ff [NUM_DEVICES];
   logic [COUNT_W-1:0]     silent_cnt_in [NUM_DEVICES];
   logic [COUNT_W-1:0]     frozen_cnt_ff [NUM_DEVICES];
   logic [COUNT_W-1:0]     frozen_cnt_in [NUM_DEVICES];
   logic [COUNT_W-1:0]     impl_cnt_ff [NUM_DEVICES];
   logic [COUNT_W-1:0]     impl_cnt_in [NUM_DEVICES];
   logic [COUNT_W-1:0]     clk_low_cnt_ff, clk_low_cnt_in;
   logic [COUNT_W-1:0]     dat_low_cnt_ff, dat_low_cnt_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   clk_stuck_ff, clk_stuck_in;
   logic                   dat_stuck_ff, dat_stuck_in;
   logic [NUM_DEVICES-1:0] nr_mask_ff, nr_mask_in;
   logic [NUM_DEVICES-1:0] to_mask_ff, to_mask_in;
   logic [NUM_DEVICES-1:0] st_mask_ff, st_mask_in;
   logic [NUM_DEVICES-1:0] im_mask_ff, im_mask_in;

   logic do_report;
   logic do_tick;

   assign do_report = s1_fire && (s1_op_ff == OP_REPORT) && s1_read_ok_ff;
   assign do_tick   = s1_fire && (s1_op_ff == OP_TICK);

   always_comb begin
      ever_in        = ever_ff;
      win_ans_in     = win_ans_ff;
      win_impl_in    = win_impl_ff;
      last_valid_in  = last_valid_ff;
      clk_low_cnt_in = clk_low_cnt_ff;
      dat_low_cnt_in = dat_low_cnt_ff;
      nr_mask_in     = '0;
      to_mask_in     = '0;
      st_mask_in     = '0;
      im_mask_in     = '0;
      if (do_tick) begin
         clk_low_cnt_in = sat_count(clk_low_cnt_ff, !s1_clk_high_ff);
         dat_low_cnt_in = sat_count(dat_low_cnt_ff, !s1_dat_high_ff);
      end
      for (int i = 0; i < NUM_DEVICES; i++) begin
         last_live_in[i]  = last_live_ff[i];
         silent_cnt_in[i] = silent_cnt_ff[i];
         frozen_cnt_in[i] = frozen_cnt_ff[i];
         impl_cnt_in[i]   = impl_cnt_ff[i];
         // numbers at or above the device count match no slot
         if (do_report && (s1_device_ff == DEVICE_W'(i))) begin
            win_ans_in[i]    = 1'b1;
            ever_in[i]       = 1'b1;
            if (!s1_plausible_ff) begin
               win_impl_in[i] = 1'b1;
            end
            frozen_cnt_in[i] = sat_count(frozen_cnt_ff[i],
               last_valid_ff[i] && (last_live_ff[i] == s1_liveness_ff));
            last_live_in[i]  = s1_liveness_ff;
            last_valid_in[i] = 1'b1;
         end
         if (do_tick && fitted_ff[i]) begin
            silent_cnt_in[i] = sat_count(silent_cnt_ff[i], !win_ans_ff[i]);
            impl_cnt_in[i]   = sat_count(impl_cnt_ff[i], win_impl_ff[i]);
            nr_mask_in[i]    = !ever_ff[i];
            to_mask_in[i]    = ever_ff[i] && (silent_cnt_in[i] >= timeout_ticks_ff);
            st_mask_in[i]    = frozen_cnt_ff[i] >= stuck_ticks_ff;
            im_mask_in[i]    = impl_cnt_in[i] >= impl_ticks_ff;
            win_ans_in[i]    = 1'b0;
            win_impl_in[i]   = 1'b0;
         end
      end
      clk_stuck_in = clk_low_cnt_in >= bus_ticks_ff;
      dat_stuck_in = dat_low_cnt_in >= bus_ticks_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ever_ff        <= '0;
         win_ans_ff     <= '0;
         win_impl_ff    <= '0;
         last_valid_ff  <= '0;
         clk_low_cnt_ff <= '0;
         dat_low_cnt_ff <= '0;
         for (int i = 0; i < NUM_DEVICES; i++) begin
            silent_cnt_ff[i] <= '0;
            frozen_cnt_ff[i] <= '0;
            impl_cnt_ff[i]   <= '0;
         end
      end else begin
         ever_ff        <= ever_in;
         win_ans_ff     <= win_ans_in;
         win_impl_ff    <= win_impl_in;
         last_valid_ff  <= last_valid_in;
         clk_low_cnt_ff <= clk_low_cnt_in;
         dat_low_cnt_ff <= dat_low_cnt_in;
         for (int i = 0; i < NUM_DEVICES; i++) begin
            silent_cnt_ff[i] <= silent_cnt_in[i];
            frozen_cnt_ff[i] <= frozen_cnt_in[i];
            impl_cnt_ff[i]   <= impl_cnt_in[i];
         end
      end
   end

   // last liveness is only read behind its valid bit
   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_DEVICES; i++) begin
         last_live_ff[i] <= last_live_in[i];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (do_tick) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_tick) begin
         clk_stuck_ff <= clk_stuck_in;
         dat_stuck_ff <= dat_stuck_in;
         nr_mask_ff   <= nr_mask_in;
         to_mask_ff   <= to_mask_in;
         st_mask_ff   <= st_mask_in;
         im_mask_ff   <= im_mask_in;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.clock_line_stuck = clk_stuck_ff;
   assign rsp_chan.data_line_stuck  = dat_stuck_ff;
   assign rsp_chan.no_response_mask = nr_mask_ff;
   assign rsp_chan.timeout_mask     = to_mask_ff;
   assign rsp_chan.stuck_mask       = st_mask_ff;
   assign rsp_chan.implausible_mask = im_mask_ff;

   // a new result only ever follows a tick leaving the input register
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && !rsp_chan.ready)) |->
         $past(s1_valid_ff && (s1_op_ff == OP_TICK)))
      else $error("result appeared without a tick");

   // a held result is never overwritten by a tick
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |-> !do_tick)
      else $error("tick overwrote a pending result");

   // unfitted devices give no bits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         (((nr_mask_ff | to_mask_ff | st_mask_ff | im_mask_ff) & ~fitted_ff) == '0))
      else $error("mask bit set for an unfitted device");

   // a device that never answered cannot time out
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((nr_mask_ff & to_mask_ff) == '0))
      else $error("no response and timeout both set");

   // a tick always closes the window of every fitted device
   assert property (@(posedge clock) disable iff (reset)
      do_tick |=> (((win_ans_ff | win_impl_ff) & $past(fitted_ff)) == '0))
      else $error("window flags not cleared by tick");

endmodule
